FILE: design/c2c_pkg.sv
// Shared constants, types and the arctangent table for the cartesian to cylindrical converter.
package c2c_pkg;

   // Default geometry
   localparam int CORDIC_STAGES_DEF = 18;
   localparam int COORD_BITS_DEF    = 32;

   // Guard bits below the coordinate LSB inside the CORDIC
   localparam int GUARD_SHIFT = 8;
   localparam int GUARD_HALF  = 128;

   // Angle accumulator in units of pi/2^30
   localparam int Z_BITS     = 32;
   localparam int TAB_BITS   = 31;
   localparam int ANGLE_BITS = 16;
   localparam int ANGLE_LSB  = 14;

   localparam logic signed [Z_BITS-1:0] HALF_PI_Z   = 32'sh2000_0000;
   localparam logic signed [Z_BITS-1:0] ANGLE_ROUND = 32'sd8192;
   localparam logic [ANGLE_BITS-1:0]    ANGLE_AXIS  = 16'h8000;
   localparam logic [ANGLE_BITS-1:0]    ANGLE_ZERO  = 16'h0000;

   // Inverse CORDIC gain, Q0.32
   localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;

   // Flags for points on an axis, carried down the pipe with the data
   typedef struct packed {
      logic y_zero;
      logic x_zero;
   } axis_type;

   // round(atan(2^-i) * 2^30 / pi)
   function automatic logic [TAB_BITS-1:0] atan_entry(input logic [4:0] idx);
      logic [TAB_BITS-1:0] val;
      unique case (idx)
         5'd0:  val = 31'd268435456;
         5'd1:  val = 31'd158466703;
         5'd2:  val = 31'd83729454;
         5'd3:  val = 31'd42502378;
         5'd4:  val = 31'd21333666;
         5'd5:  val = 31'd10677233;
         5'd6:  val = 31'd5339919;
         5'd7:  val = 31'd2670123;
         5'd8:  val = 31'd1335082;
         5'd9:  val = 31'd667543;
         5'd10: val = 31'd333772;
         5'd11: val = 31'd166886;
         5'd12: val = 31'd83443;
         5'd13: val = 31'd41722;
         5'd14: val = 31'd20861;
         5'd15: val = 31'd10430;
         5'd16: val = 31'd5215;
         5'd17: val = 31'd2608;
         5'd18: val = 31'd1304;
         5'd19: val = 31'd652;
         5'd20: val = 31'd326;
         5'd21: val = 31'd163;
         5'd22: val = 31'd81;
         5'd23: val = 31'd41;
         5'd24: val = 31'd20;
         5'd25: val = 31'd10;
         5'd26: val = 31'd5;
         5'd27: val = 31'd3;
         5'd28: val = 31'd1;
         5'd29: val = 31'd1;
         5'd30: val = 31'd0;
         5'd31: val = 31'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: design/cartesian_to_cylindrical.sv
// Top level: pipelined vectoring CORDIC from cartesian (x, y, z) to (radius, angle, height).
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+--------------------------
//   request | req_x_coord, req_y_coord, req_z_coord    | start high, busy low
//   result  | rsp_radius, rsp_angle, rsp_height        | rsp_strobe, one cycle
//
// The pipe holds one fold stage, one register per micro-rotation, two multiply stages
// for the gain and one rounding stage.
// A new point may enter every cycle; busy is high only while reset is asserted.
// Reset clears the valid bits of every stage, dropping points in flight.
// Nothing stalls: the result strobe lasts one cycle and the receiver must take it.
module cartesian_to_cylindrical import c2c_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic signed [COORD_BITS-1:0] req_z_coord,
   output logic                         rsp_strobe,
   output logic [COORD_BITS-1:0]        rsp_radius,
   output logic [ANGLE_BITS-1:0]        rsp_angle,
   output logic signed [COORD_BITS-1:0] rsp_height
);

   localparam int DW = COORD_BITS + 11;

   logic                         v_chain [0:CORDIC_STAGES];
   logic signed [DW-1:0]         x_chain [0:CORDIC_STAGES];
   logic signed [DW-1:0]         y_chain [0:CORDIC_STAGES];
   logic signed [Z_BITS-1:0]     z_chain [0:CORDIC_STAGES];
   axis_type                     f_chain [0:CORDIC_STAGES];
   logic signed [COORD_BITS-1:0] h_chain [0:CORDIC_STAGES];

   // Refuse transfers only while reset holds the pipe
   assign busy = reset;

   // Fold and scale the incoming point
   c2c_prerot #(
      .COORD_BITS (COORD_BITS),
      .DW         (DW)
   ) u_prerot (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_x       (req_x_coord),
      .in_y       (req_y_coord),
      .in_z       (req_z_coord),
      .out_valid  (v_chain[0]),
      .out_x      (x_chain[0]),
      .out_y      (y_chain[0]),
      .out_z      (z_chain[0]),
      .out_flags  (f_chain[0]),
      .out_height (h_chain[0])
   );

   // Chain the micro-rotations, one register stage each
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      c2c_stage #(
         .COORD_BITS (COORD_BITS),
         .DW         (DW),
         .SHIFT      (i)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (v_chain[i]),
         .in_x       (x_chain[i]),
         .in_y       (y_chain[i]),
         .in_z       (z_chain[i]),
         .in_flags   (f_chain[i]),
         .in_height  (h_chain[i]),
         .out_valid  (v_chain[i+1]),
         .out_x      (x_chain[i+1]),
         .out_y      (y_chain[i+1]),
         .out_z      (z_chain[i+1]),
         .out_flags  (f_chain[i+1]),
         .out_height (h_chain[i+1])
      );
   end

   // Remove the gain, round and drive the result ports
   c2c_gain #(
      .COORD_BITS (COORD_BITS),
      .DW         (DW)
   ) u_gain (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v_chain[CORDIC_STAGES]),
      .in_x       (x_chain[CORDIC_STAGES]),
      .in_z       (z_chain[CORDIC_STAGES]),
      .in_flags   (f_chain[CORDIC_STAGES]),
      .in_height  (h_chain[CORDIC_STAGES]),
      .out_valid  (rsp_strobe),
      .out_radius (rsp_radius),
      .out_angle  (rsp_angle),
      .out_height (rsp_height)
   );

`ifndef NO_ASSERTIONS
   // A point leaving the rotations entered them and passed through every micro-rotation register
   assert property (@(posedge clock) disable iff (reset)
      v_chain[CORDIC_STAGES] |-> $past(v_chain[0], CORDIC_STAGES))
      else $error("valid bit lost its place in the rotation chain");

   // A result strobe follows a point at the end of the rotations through the two multiply stages and the rounding stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(v_chain[CORDIC_STAGES], 3))
      else $error("result strobe without a point in the gain stages");

   // Height leaves the pipe equal to the z of the transfer that carried it
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_height == $past(req_z_coord, CORDIC_STAGES + 4)))
      else $error("height does not match its request");
`endif

endmodule

FILE: design/c2c_prerot.sv
// Input stage: fold the point into the first quadrant and scale it for the CORDIC.
module c2c_prerot import c2c_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DW         = COORD_BITS_DEF + 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic signed [COORD_BITS-1:0] in_z,
   output logic                         out_valid,
   output logic signed [DW-1:0]         out_x,
   output logic signed [DW-1:0]         out_y,
   output logic signed [Z_BITS-1:0]     out_z,
   output axis_type                     out_flags,
   output logic signed [COORD_BITS-1:0] out_height
);

   logic signed [COORD_BITS:0] sx, sy, nx, ny, px, py;
   logic                       left;

   logic                         valid_ff;
   logic signed [DW-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [Z_BITS-1:0]     z_ff, z_in;
   axis_type                     flags_ff, flags_in;
   logic signed [COORD_BITS-1:0] height_ff;

   // Mirror the lower half-plane, then turn the left quadrant by -pi/2
   always_comb begin
      sx   = $signed({in_x[COORD_BITS-1], in_x});
      sy   = $signed({in_y[COORD_BITS-1], in_y});
      nx   = sy[COORD_BITS] ? -sx : sx;
      ny   = sy[COORD_BITS] ? -sy : sy;
      left = nx[COORD_BITS];
      px   = left ? ny : nx;
      py   = left ? -nx : ny;
      x_in = DW'($signed({px, {GUARD_SHIFT{1'b0}}}));
      y_in = DW'($signed({py, {GUARD_SHIFT{1'b0}}}));
      z_in = left ? HALF_PI_Z : '0;
      flags_in.y_zero = (in_y == '0);
      flags_in.x_zero = (in_x == '0);
   end

   // Advance the valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      flags_ff  <= flags_in;
      height_ff <= in_z;
   end

   assign out_valid  = valid_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_z      = z_ff;
   assign out_flags  = flags_ff;
   assign out_height = height_ff;

`ifndef NO_ASSERTIONS
   // The folded point always lies in the closed first quadrant
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (!out_x[DW-1] && !out_y[DW-1]))
      else $error("pre-rotation left a negative coordinate");
`endif

endmodule

FILE: design/c2c_stage.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
module c2c_stage import c2c_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DW         = COORD_BITS_DEF + 11,
   parameter int SHIFT      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [DW-1:0]         in_x,
   input  logic signed [DW-1:0]         in_y,
   input  logic signed [Z_BITS-1:0]     in_z,
   input  axis_type                     in_flags,
   input  logic signed [COORD_BITS-1:0] in_height,
   output logic                         out_valid,
   output logic signed [DW-1:0]         out_x,
   output logic signed [DW-1:0]         out_y,
   output logic signed [Z_BITS-1:0]     out_z,
   output axis_type                     out_flags,
   output logic signed [COORD_BITS-1:0] out_height
);

   logic signed [DW-1:0]     dx, dy;
   logic signed [Z_BITS-1:0] step_ang;

   logic                         valid_ff;
   logic signed [DW-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [Z_BITS-1:0]     z_ff, z_in;
   axis_type                     flags_ff;
   logic signed [COORD_BITS-1:0] height_ff;

   // Rotate toward the x axis by atan(2^-SHIFT)
   always_comb begin
      dx       = in_y >>> SHIFT;
      dy       = in_x >>> SHIFT;
      step_ang = $signed(Z_BITS'(atan_entry(5'(SHIFT))));
      if (!in_y[DW-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + step_ang;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - step_ang;
      end
   end

   // Advance the valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      flags_ff  <= in_flags;
      height_ff <= in_height;
   end

   assign out_valid  = valid_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_z      = z_ff;
   assign out_flags  = flags_ff;
   assign out_height = height_ff;

`ifndef NO_ASSERTIONS
   // X only grows from a non-negative start, so it never turns negative
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !out_x[DW-1])
      else $error("CORDIC x went negative");
`endif

endmodule

FILE: design/c2c_gain.sv
// Gain correction, rounding and saturation of the radius, and angle rounding.
module c2c_gain import c2c_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int DW         = COORD_BITS_DEF + 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [DW-1:0]         in_x,
   input  logic signed [Z_BITS-1:0]     in_z,
   input  axis_type                     in_flags,
   input  logic signed [COORD_BITS-1:0] in_height,
   output logic                         out_valid,
   output logic [COORD_BITS-1:0]        out_radius,
   output logic [ANGLE_BITS-1:0]        out_angle,
   output logic signed [COORD_BITS-1:0] out_height
);

   localparam int RXW = (DW - 1 > 33) ? DW - 1 : 33;
   localparam int HIW = RXW - 32;
   localparam int PW  = RXW + 1;

   // First multiply stage: low half times the inverse gain
   logic [RXW-1:0]            rx;
   logic [63:0]               lo_mult;
   logic [64:0]               lo_sum;
   logic signed [Z_BITS-1:0]  z_round;
   logic [ANGLE_BITS-1:0]     ang_in;

   logic                         valid1_ff;
   logic [32:0]                  low1_ff;
   logic [HIW-1:0]               hi1_ff;
   logic [ANGLE_BITS-1:0]        ang1_ff;
   logic signed [COORD_BITS-1:0] height1_ff;

   always_comb begin
      rx      = in_x[DW-1] ? '0 : RXW'(in_x[DW-2:0]);
      lo_mult = 64'(rx[31:0]) * 64'(INV_GAIN_Q32);
      lo_sum  = {1'b0, lo_mult} + 65'h0_8000_0000;
      z_round = in_z + ANGLE_ROUND;
      priority if (in_flags.y_zero) begin
         ang_in = ANGLE_ZERO;
      end else if (in_flags.x_zero) begin
         ang_in = ANGLE_AXIS;
      end else begin
         ang_in = z_round[ANGLE_LSB+ANGLE_BITS-1:ANGLE_LSB];
      end
   end

   // Second multiply stage: high half times the inverse gain plus the low carry
   logic [RXW-1:0] hi_mult;
   logic [PW-1:0]  prod_in;

   logic                         valid2_ff;
   logic [PW-1:0]                prod2_ff;
   logic [ANGLE_BITS-1:0]        ang2_ff;
   logic signed [COORD_BITS-1:0] height2_ff;

   always_comb begin
      hi_mult = RXW'(hi1_ff) * RXW'(INV_GAIN_Q32);
      prod_in = PW'(hi_mult) + PW'(low1_ff);
   end

   // Final stage: drop the guard bits with rounding and clamp
   logic [PW:0]           rnd_sum;
   logic [PW-8:0]         rad_full;
   logic [COORD_BITS-1:0] radius_in;

   logic                         valid3_ff;
   logic [COORD_BITS-1:0]        radius3_ff;
   logic [ANGLE_BITS-1:0]        ang3_ff;
   logic signed [COORD_BITS-1:0] height3_ff;

   always_comb begin
      rnd_sum   = (PW+1)'(prod2_ff) + (PW+1)'(GUARD_HALF);
      rad_full  = rnd_sum[PW:GUARD_SHIFT];
      radius_in = (|rad_full[PW-8:COORD_BITS]) ? '1 : rad_full[COORD_BITS-1:0];
   end

   // Advance the valid bits under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // Hold the payload of each stage
   always_ff @(posedge clock) begin
      low1_ff    <= lo_sum[64:32];
      hi1_ff     <= rx[RXW-1:32];
      ang1_ff    <= ang_in;
      height1_ff <= in_height;
      prod2_ff   <= prod_in;
      ang2_ff    <= ang1_ff;
      height2_ff <= height1_ff;
      radius3_ff <= radius_in;
      ang3_ff    <= ang2_ff;
      height3_ff <= height2_ff;
   end

   assign out_valid  = valid3_ff;
   assign out_radius = radius3_ff;
   assign out_angle  = ang3_ff;
   assign out_height = height3_ff;

endmodule

FILE: sim/tb_cartesian_to_cylindrical.sv
// Self-checking testbench for the cartesian to cylindrical CORDIC converter.
module tb_cartesian_to_cylindrical;
   import c2c_pkg::*;

   localparam int CW            = COORD_BITS_DEF;
   localparam int STAGES        = CORDIC_STAGES_DEF;
   localparam int SETTLE_CYCLES = STAGES + 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 284;

   localparam logic [CW-1:0] C_MAX   = 32'h7FFF_FFFF;
   localparam logic [CW-1:0] C_MIN   = 32'h8000_0000;
   localparam logic [CW-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [CW-1:0] NEG_ONE = 32'hFFFF_0000;

   typedef struct packed {
      logic [CW-1:0]         radius;
      logic [ANGLE_BITS-1:0] angle;
      logic [CW-1:0]         height;
   } cyl_point_type;

   // One stimulus row; a set pin flag replaces the computed field by the typed value
   typedef struct packed {
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic [CW-1:0]         z;
      logic                  pin_radius;
      logic [CW-1:0]         radius;
      logic                  pin_angle;
      logic [ANGLE_BITS-1:0] angle;
   } point_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic signed [CW-1:0]  req_x_coord;
   logic signed [CW-1:0]  req_y_coord;
   logic signed [CW-1:0]  req_z_coord;
   logic                  rsp_strobe;
   logic [CW-1:0]         rsp_radius;
   logic [ANGLE_BITS-1:0] rsp_angle;
   logic signed [CW-1:0]  rsp_height;

   cyl_point_type expected_cyl[$];
   int            mismatch_count = 0;
   int            stall_run = 0;

   // Arctangent of 2^-i in units of pi/2^30
   longint atan_q30 [0:31] = '{
      268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
      5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
      5, 3, 1, 1, 0, 0
   };

   point_row_type dir_rows [0:24] = '{
      // origin, with the height at rest and at both extremes
      '{32'h0, 32'h0, 32'h0,         1'b1, 32'h0, 1'b1, ANGLE_ZERO},
      '{32'h0, 32'h0, C_MIN,         1'b1, 32'h0, 1'b1, ANGLE_ZERO},
      '{32'h0, 32'h0, C_MAX,         1'b1, 32'h0, 1'b1, ANGLE_ZERO},
      // x axis, both signs
      '{ONE_Q16, 32'h0, 32'h1234_5678, 1'b0, 32'h0, 1'b1, ANGLE_ZERO},
      '{NEG_ONE, 32'h0, 32'hEDCB_A987, 1'b0, 32'h0, 1'b1, ANGLE_ZERO},
      '{C_MAX,   32'h0, 32'h0000_0001, 1'b0, 32'h0, 1'b1, ANGLE_ZERO},
      '{C_MIN,   32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, ANGLE_ZERO},
      // y axis, both signs
      '{32'h0, ONE_Q16, 32'h0, 1'b0, 32'h0, 1'b1, ANGLE_AXIS},
      '{32'h0, NEG_ONE, 32'h0, 1'b0, 32'h0, 1'b1, ANGLE_AXIS},
      '{32'h0, C_MAX,   32'h0, 1'b0, 32'h0, 1'b1, ANGLE_AXIS},
      '{32'h0, C_MIN,   32'h0, 1'b0, 32'h0, 1'b1, ANGLE_AXIS},
      // corners of the coordinate range
      '{C_MAX, C_MAX, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{C_MIN, C_MIN, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{C_MIN, C_MAX, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{C_MAX, C_MIN, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      // one LSB in each quadrant
      '{32'h1,         32'h1,         32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'hFFFF_FFFF, 32'h1,         32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'h1,         32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      // angle just under pi, just under zero, just over zero
      '{32'hFFF0_0000, 32'h1,         32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'h0010_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'h0010_0000, 32'h1,         32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      '{C_MIN, 32'h1, 32'h0, 1'b0, 32'h0, 1'b0, 16'h0},
      // alternating bit patterns
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 16'h0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 32'h0, 1'b0, 16'h0}
   };

   cartesian_to_cylindrical DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .req_z_coord (req_z_coord),
      .rsp_strobe  (rsp_strobe),
      .rsp_radius  (rsp_radius),
      .rsp_angle   (rsp_angle),
      .rsp_height  (rsp_height)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Vectoring CORDIC: fold to the first quadrant, rotate, remove gain, round
   function automatic cyl_point_type to_cylinder(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y,
                                                 input logic [CW-1:0] z);
      longint        ux, uy, cx, cy, cz, sx, sy, swap, zsum;
      logic [63:0]   mag, lo_part, prod, rad;
      cyl_point_type res;
      ux = x;
      uy = y;
      cz = 0;
      if (uy < 0) begin
         ux = -ux;
         uy = -uy;
      end
      if (ux < 0) begin
         swap = ux;
         ux   = uy;
         uy   = -swap;
         cz   = HALF_PI_Z;
      end
      cx = ux * (64'sd1 <<< GUARD_SHIFT);
      cy = uy * (64'sd1 <<< GUARD_SHIFT);
      for (int i = 0; i < STAGES; i++) begin
         sx = cy >>> (i % 32);
         sy = cx >>> (i % 32);
         if (cy >= 0) begin
            cx = cx + sx;
            cy = cy - sy;
            cz = cz + atan_q30[i % 32];
         end else begin
            cx = cx - sx;
            cy = cy + sy;
            cz = cz - atan_q30[i % 32];
         end
      end
      // scale by the inverse gain, rounding the split product
      mag     = (cx > 0) ? 64'(cx) : 64'd0;
      lo_part = {32'd0, mag[31:0]};
      prod    = (mag >> 32) * {32'd0, INV_GAIN_Q32}
              + ((lo_part * {32'd0, INV_GAIN_Q32} + 64'h8000_0000) >> 32);
      rad     = (prod + 64'(GUARD_HALF)) >> GUARD_SHIFT;
      if (rad > {{(64-CW){1'b0}}, {CW{1'b1}}})
         rad = {{(64-CW){1'b0}}, {CW{1'b1}}};
      res.radius = rad[CW-1:0];
      zsum = cz + ANGLE_ROUND;
      if (y == 0)
         res.angle = ANGLE_ZERO;
      else if (x == 0)
         res.angle = ANGLE_AXIS;
      else
         res.angle = zsum[ANGLE_LSB +: ANGLE_BITS];
      res.height = z;
      return res;
   endfunction

   // Mix full range, extremes, zero and small magnitudes
   function automatic logic [CW-1:0] pick_coord();
      logic [CW-1:0] v;
      int unsigned   k;
      v = $urandom;
      k = $urandom_range(CW - 1);
      case ($urandom_range(7))
         0: v = '0;
         1: v = $urandom_range(1) ? C_MAX : C_MIN;
         2: v = $urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF;
         3, 4: v = $signed(v) >>> k;
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
   endtask

   // Idle at random, then hold the point until its transfer and record the expectation
   task automatic send_point(input point_row_type row, input int idle_pct);
      cyl_point_type want;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_x_coord <= row.x;
      req_y_coord <= row.y;
      req_z_coord <= row.z;
      do @(posedge clock); while (busy);
      want = to_cylinder(row.x, row.y, row.z);
      if (row.pin_radius)
         want.radius = row.radius;
      if (row.pin_angle)
         want.angle = row.angle;
      expected_cyl.push_back(want);
   endtask

   // Drop start and hold off until every pending result has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_cyl.size() != 0)
         @(posedge clock);
   endtask

   // Stimulus: reset, directed table, then three random phases
   initial begin
      point_row_type row;
      int            idle_pct;
      reset       = 1'b1;
      start       = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_z_coord = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[r])
         send_point(dir_rows[r], 0);
      wait_drained();
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 24 : (ph == 1) ? 82 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            row   = '0;
            row.x = pick_coord();
            row.y = pick_coord();
            row.z = $urandom;
            send_point(row, idle_pct);
         end
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Check each result transfer against the oldest expectation; watch for a hang
   always @(posedge clock) begin
      cyl_point_type want;
      if (rsp_strobe === 1'b1) begin
         if (expected_cyl.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_radius, 64'd0);
         end else begin
            want = expected_cyl.pop_front();
            if (rsp_radius !== want.radius)
               report_mismatch("radius", rsp_radius, want.radius);
            if (rsp_angle !== want.angle)
               report_mismatch("angle", rsp_angle, want.angle);
            if (rsp_height !== want.height)
               report_mismatch("height", rsp_height, want.height);
         end
      end
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1)
         stall_run = 0;
      else
         stall_run++;
      if (stall_run >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
